FILE: sv/ctpq_pkg.sv
`timescale 1ns / 1ps
package ctpq_pkg;
  localparam int SLOT_COUNT_D    = 16;
  localparam int QUEUE_COUNT_D   = 4;
  localparam int CHANNEL_COUNT_D = 2;

  localparam logic [1:0] OP_REQ     = 2'd0;
  localparam logic [1:0] OP_CONFIRM = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] MB_FREE = 2'd0;
  localparam logic [1:0] MB_BUSY = 2'd1;

  localparam logic [2:0] ST_FORWARDED  = 3'd0;
  localparam logic [2:0] ST_QUEUED     = 3'd1;
  localparam logic [2:0] ST_OVERWRITE  = 3'd2;
  localparam logic [2:0] ST_OFFLINE    = 3'd3;
  localparam logic [2:0] ST_DRV_ERROR  = 3'd4;
  localparam logic [2:0] ST_CONFIRMED  = 3'd5;
  localparam logic [2:0] ST_IGNORED    = 3'd6;
  localparam logic [2:0] ST_CLEARED    = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_WALK, S_LINK, S_CLEAR, S_OUT
  } ctl_state_t;

  typedef struct packed {
    logic load;      // capture input beat
    logic walk_init; // start insertion walk at queue head
    logic walk_step; // advance one link
    logic do_link;   // splice new entry in
    logic clr_init;
    logic clr_step;
    logic fin;       // write result register
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic clr_done;
    logic need_walk;  // decode: request to be buffered
    logic need_clear; // decode: valid clear op
  } dp_sts_t;
endpackage

FILE: sv/can_tx_priority_queue.sv
`timescale 1ns / 1ps
// CAN transmit priority buffer: one buffer per slot, buffered slots linked in
// ascending id order per hardware queue. One result beat per input beat. A
// request that is buffered walks its queue one link a cycle, then is linked in;
// a clear sweeps every slot; other ops go from decode straight to the output
// handoff, which waits for out_tready. One op is in flight at a time.
module can_tx_priority_queue
  import ctpq_pkg::*;
#(
  parameter int SLOT_COUNT    = SLOT_COUNT_D,
  parameter int QUEUE_COUNT   = QUEUE_COUNT_D,
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_D
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[1:0] pdu_slot[5:2] target_queue[7:6] channel[8] can_id[40:9]
  // length[44:41] payload[108:45] zero[111:109]
  input  logic [111:0] in_tdata,
  // channel_started[0] tx_online[1] confirm_enabled[2] mailbox_state[4:3]
  input  logic [4:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0] send_valid[3] send_slot[7:4] send_id[39:8] send_length[43:40]
  // send_payload[107:44] zero[111:108]
  output logic [111:0] out_tdata
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [107:0] res;

  ctpq_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .sts, .cmd
  );

  ctpq_dp #(
    .SLOT_COUNT(SLOT_COUNT), .QUEUE_COUNT(QUEUE_COUNT), .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_dp (
    .clk, .rst_n, .in_data(in_tdata), .in_flags(in_tuser), .cmd, .sts, .res_data(res)
  );

  assign out_tdata = {4'd0, res};

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.walk_step && cmd.do_link)) else $error("walk and link together");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result pending");
  a_fin_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_tvalid) else $error("result not shown");
endmodule

FILE: sv/ctpq_ctrl.sv
`timescale 1ns / 1ps
module ctpq_ctrl
  import ctpq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);
  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.need_walk) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else if (sts.need_clear) begin
          cmd.clr_init = 1'b1;
          state_nxt    = S_CLEAR;
        end else begin
          cmd.fin   = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_WALK: begin
        if (sts.walk_done) state_nxt = S_LINK;
        else               cmd.walk_step = 1'b1;
      end
      S_LINK: begin
        cmd.do_link = 1'b1;
        cmd.fin     = 1'b1;
        state_nxt   = S_OUT;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          cmd.fin   = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

FILE: sv/ctpq_dp.sv
`timescale 1ns / 1ps
module ctpq_dp
  import ctpq_pkg::*;
#(
  parameter int SLOT_COUNT    = SLOT_COUNT_D,
  parameter int QUEUE_COUNT   = QUEUE_COUNT_D,
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_D
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [111:0]  in_data,
  input  logic [4:0]    in_flags,
  input  dp_cmd_t       cmd,
  output dp_sts_t       sts,
  output logic [107:0]  res_data
);
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int LW = SW + 1;
  localparam logic [LW-1:0] EMPTY = LW'(SLOT_COUNT);

  logic [1:0]  op_r;
  logic [3:0]  slot_in_r;
  logic [1:0]  q_in_r;
  logic        ch_in_r;
  logic [31:0] id_r;
  logic [3:0]  len_r;
  logic [63:0] data_r;
  logic        started_r, online_r, confirm_r;
  logic [1:0]  mbox_r;

  logic [SLOT_COUNT-1:0] full_r;
  logic [3:0]    slen_m  [SLOT_COUNT];
  logic [63:0]   spay_m  [SLOT_COUNT];
  logic [31:0]   sid_m   [SLOT_COUNT];
  logic [QW-1:0] sq_m    [SLOT_COUNT];
  logic [CW-1:0] sch_m   [SLOT_COUNT];
  logic [LW-1:0] slink_m [SLOT_COUNT];
  logic [LW-1:0] head_r  [QUEUE_COUNT];

  logic [LW-1:0] prev_r, cur_r;
  logic [LW:0]   steps_r;
  logic [SW-1:0] clr_idx_r;
  logic [107:0]  res_r;
  logic [107:0]  res_nxt;

  logic [3:0]  len_in;
  logic [63:0] data_in;
  always_comb begin
    len_in = (in_data[44:41] > 4'd8) ? 4'd8 : in_data[44:41];
    for (int b = 0; b < 8; b++)
      data_in[b*8 +: 8] = (4'(b) < len_in) ? in_data[45 + b*8 +: 8] : 8'h00;
  end

  logic range_ok;
  logic [SW-1:0] s_idx;
  logic [QW-1:0] q_idx;
  logic [CW-1:0] c_idx;
  assign range_ok = (32'(slot_in_r) < SLOT_COUNT) && (32'(q_in_r) < QUEUE_COUNT)
                    && (32'(ch_in_r) < CHANNEL_COUNT);
  assign s_idx = SW'(slot_in_r);
  assign q_idx = QW'(q_in_r);
  assign c_idx = CW'(ch_in_r);

  logic is_req_buf;
  assign is_req_buf = (op_r == OP_REQ) && range_ok && started_r && online_r
                      && !full_r[s_idx] && (mbox_r == MB_BUSY);
  assign sts.need_walk  = is_req_buf;
  assign sts.need_clear = (op_r == OP_CLEAR) && (32'(ch_in_r) < CHANNEL_COUNT);
  assign sts.walk_done  = (cur_r >= EMPTY) || (32'(steps_r) >= SLOT_COUNT)
                          || (sid_m[SW'(cur_r)] > id_r);
  assign sts.clr_done   = (32'(clr_idx_r) == SLOT_COUNT - 1);

  logic [LW-1:0] h_sel;
  logic          h_ok;
  assign h_sel = head_r[q_idx];
  assign h_ok  = h_sel < EMPTY;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_data[1:0];
      slot_in_r <= in_data[5:2];
      q_in_r    <= in_data[7:6];
      ch_in_r   <= in_data[8];
      id_r      <= in_data[40:9];
      len_r     <= len_in;
      data_r    <= data_in;
      started_r <= in_flags[0];
      online_r  <= in_flags[1];
      confirm_r <= in_flags[2];
      mbox_r    <= in_flags[4:3];
    end
    if (cmd.walk_init) begin
      prev_r  <= EMPTY;
      cur_r   <= head_r[q_idx];
      steps_r <= '0;
    end
    if (cmd.walk_step) begin
      prev_r  <= cur_r;
      cur_r   <= slink_m[SW'(cur_r)];
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.clr_init) clr_idx_r <= '0;
    else if (cmd.clr_step) clr_idx_r <= clr_idx_r + 1'b1;
    if (cmd.fin && op_r == OP_REQ && range_ok && started_r && online_r
        && full_r[s_idx]) begin
      slen_m[s_idx] <= len_r;
      spay_m[s_idx] <= data_r;
    end
    if (cmd.do_link) begin
      slen_m[s_idx]  <= len_r;
      spay_m[s_idx]  <= data_r;
      sid_m[s_idx]   <= id_r;
      sq_m[s_idx]    <= q_idx;
      sch_m[s_idx]   <= c_idx;
      slink_m[s_idx] <= (cur_r >= EMPTY) ? EMPTY : cur_r;
      if (prev_r < EMPTY) slink_m[SW'(prev_r)] <= LW'(s_idx);
    end
    if (cmd.fin) res_r <= res_nxt;
  end

  // control state: valid bits and queue heads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) head_r[i] <= EMPTY;
    end else begin
      if (cmd.do_link) begin
        full_r[s_idx] <= 1'b1;
        if (prev_r >= EMPTY) head_r[q_idx] <= LW'(s_idx);
      end
      if (cmd.fin && op_r == OP_CONFIRM && range_ok && confirm_r) begin
        if (h_ok) begin
          full_r[SW'(h_sel)] <= 1'b0;
          head_r[q_idx] <= (slink_m[SW'(h_sel)] < EMPTY) ? slink_m[SW'(h_sel)] : EMPTY;
        end else head_r[q_idx] <= EMPTY;
      end
      if (cmd.clr_step && full_r[clr_idx_r] && sch_m[clr_idx_r] == c_idx) begin
        full_r[clr_idx_r] <= 1'b0;
        if (32'(sq_m[clr_idx_r]) < QUEUE_COUNT) head_r[sq_m[clr_idx_r]] <= EMPTY;
      end
    end
  end

  // result: {payload, length, id, slot, valid, status}
  always_comb begin
    res_nxt = '0;
    case (op_r)
      OP_REQ: begin
        if (!range_ok)                  res_nxt[2:0] = ST_IGNORED;
        else if (!started_r || !online_r) res_nxt[2:0] = ST_OFFLINE;
        else if (full_r[s_idx])         res_nxt[2:0] = ST_OVERWRITE;
        else if (mbox_r == MB_FREE)
          res_nxt = {data_r, len_r, id_r, slot_in_r, 1'b1, ST_FORWARDED};
        else if (mbox_r != MB_BUSY)     res_nxt[2:0] = ST_DRV_ERROR;
        else                            res_nxt[2:0] = ST_QUEUED;
      end
      OP_CONFIRM: begin
        if (!range_ok || !confirm_r) res_nxt[2:0] = ST_IGNORED;
        else if (!h_ok)              res_nxt[2:0] = ST_CONFIRMED;
        else res_nxt = {spay_m[SW'(h_sel)], slen_m[SW'(h_sel)], sid_m[SW'(h_sel)],
                        4'(h_sel), 1'b1, ST_CONFIRMED};
      end
      OP_CLEAR: res_nxt[2:0] = (32'(ch_in_r) < CHANNEL_COUNT) ? ST_CLEARED : ST_IGNORED;
      default:  res_nxt[2:0] = ST_IGNORED;
    endcase
  end

  assign res_data = res_r;
endmodule
